// ----- design/sfb_pkg.sv -----
// ----------------------------------------------------------------------------
// Serial frame builder package
// Shared constants, slot codes and the burst descriptor type.
// ----------------------------------------------------------------------------
package sfb_pkg;

   localparam logic [7:0] HEAD0_BYTE = 8'hAA;
   localparam logic [7:0] HEAD1_BYTE = 8'h55;
   localparam logic [7:0] TAIL0_BYTE = 8'hCC;
   localparam logic [7:0] TAIL1_BYTE = 8'h33;

   typedef logic [3:0] slot_type;

   localparam slot_type SLOT_HEAD0 = 4'd0;
   localparam slot_type SLOT_HEAD1 = 4'd1;
   localparam slot_type SLOT_DST   = 4'd2;
   localparam slot_type SLOT_SRC   = 4'd3;
   localparam slot_type SLOT_CMD   = 4'd4;
   localparam slot_type SLOT_MID   = 4'd5;
   localparam slot_type SLOT_SUM   = 4'd6;
   localparam slot_type SLOT_TAIL0 = 4'd7;
   localparam slot_type SLOT_TAIL1 = 4'd8;

   typedef struct packed {
      logic [7:0] dst;
      logic [7:0] src;
      logic [7:0] cmd;
      logic [7:0] mid;
      logic [7:0] sum;
      slot_type   first_slot;
      slot_type   last_slot;
   } burst_type;

endpackage

// ----- design/sfb_framer.sv -----
// ----------------------------------------------------------------------------
// Serial frame builder: framer
// Holds frame state; makes a burst of each accepted start or in-frame data byte.
// ----------------------------------------------------------------------------
module sfb_framer (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               op,
   input  logic [7:0]         dst_node,
   input  logic [7:0]         src_node,
   input  logic [7:0]         command,
   input  logic [7:0]         payload_length,
   input  logic [7:0]         data_byte,
   output logic               burst_valid,
   output sfb_pkg::burst_type burst
);

   logic       frame_open_ff, frame_open_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [9:0] head_sum;
   logic [7:0] left_dec;

   always_comb begin
      head_sum       = {2'b00, dst_node} + {2'b00, src_node}
                     + {2'b00, command} + {2'b00, payload_length};
      left_dec       = bytes_left_ff - 8'd1;
      frame_open_in  = frame_open_ff;
      bytes_left_in  = bytes_left_ff;
      running_sum_in = running_sum_ff;
      burst_valid    = 1'b0;
      burst.dst        = dst_node;
      burst.src        = src_node;
      burst.cmd        = command;
      burst.mid        = payload_length;
      burst.sum        = head_sum[7:0];
      burst.first_slot = sfb_pkg::SLOT_HEAD0;
      burst.last_slot  = sfb_pkg::SLOT_MID;
      if (accept) begin
         if (!op) begin
            burst_valid    = 1'b1;
            running_sum_in = head_sum[7:0];
            bytes_left_in  = payload_length;
            frame_open_in  = 1'b1;
            if (payload_length == 8'd0) begin
               burst.last_slot = sfb_pkg::SLOT_TAIL1;
               frame_open_in   = 1'b0;
            end
         end else if (frame_open_ff) begin
            burst_valid      = 1'b1;
            burst.mid        = data_byte;
            burst.sum        = running_sum_ff + data_byte;
            burst.first_slot = sfb_pkg::SLOT_MID;
            running_sum_in   = running_sum_ff + data_byte;
            bytes_left_in    = left_dec;
            if (left_dec == 8'd0) begin
               burst.last_slot = sfb_pkg::SLOT_TAIL1;
               frame_open_in   = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff  <= 1'b0;
         bytes_left_ff  <= 8'd0;
         running_sum_ff <= 8'd0;
      end else begin
         frame_open_ff  <= frame_open_in;
         bytes_left_ff  <= bytes_left_in;
         running_sum_ff <= running_sum_in;
      end
   end

endmodule

// ----- design/sfb_serializer.sv -----
// ----------------------------------------------------------------------------
// Serial frame builder: serializer
// Holds one burst; sends one byte per unstalled cycle into the result register.
// ----------------------------------------------------------------------------
module sfb_serializer (
   input  logic               clock,
   input  logic               reset,
   input  logic               burst_valid,
   input  sfb_pkg::burst_type burst,
   output logic               burst_free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_frame_last
);

   sfb_pkg::burst_type desc_ff;
   logic               desc_valid_ff;
   sfb_pkg::slot_type  idx_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_byte_ff;
   logic               rsp_last_ff;
   logic               out_load;
   logic               desc_done;
   logic [7:0]         byte_in;

   always_comb begin
      out_load   = desc_valid_ff && (!rsp_valid_ff || rsp_ready);
      desc_done  = out_load && (idx_ff == desc_ff.last_slot);
      burst_free = !desc_valid_ff || desc_done;
      case (idx_ff)
         sfb_pkg::SLOT_HEAD0: byte_in = sfb_pkg::HEAD0_BYTE;
         sfb_pkg::SLOT_HEAD1: byte_in = sfb_pkg::HEAD1_BYTE;
         sfb_pkg::SLOT_DST:   byte_in = desc_ff.dst;
         sfb_pkg::SLOT_SRC:   byte_in = desc_ff.src;
         sfb_pkg::SLOT_CMD:   byte_in = desc_ff.cmd;
         sfb_pkg::SLOT_MID:   byte_in = desc_ff.mid;
         sfb_pkg::SLOT_SUM:   byte_in = desc_ff.sum;
         sfb_pkg::SLOT_TAIL0: byte_in = sfb_pkg::TAIL0_BYTE;
         sfb_pkg::SLOT_TAIL1: byte_in = sfb_pkg::TAIL1_BYTE;
         default:             byte_in = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (burst_valid) begin
            desc_valid_ff <= 1'b1;
         end else if (desc_done) begin
            desc_valid_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (burst_valid) begin
         desc_ff <= burst;
         idx_ff  <= burst.first_slot;
      end else if (out_load) begin
         idx_ff <= idx_ff + 4'd1;
      end
      if (out_load) begin
         rsp_byte_ff <= byte_in;
         rsp_last_ff <= (idx_ff == sfb_pkg::SLOT_TAIL1);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

// ----- design/serial_frame_builder_core.sv -----
// ----------------------------------------------------------------------------
// Serial frame builder core
// Builds length-framed packets with an 8-bit sum checksum as a byte stream.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Contents
//  req_      in         req_valid/req_ready  op, header fields or one data byte
//  rsp_      out        rsp_valid/rsp_ready  one frame byte and end-of-frame flag
//
// A transaction becomes a burst sent one byte per cycle while rsp_ready allows:
// one byte for data, four for the last data byte of a frame, six for a start and
// nine for an empty frame. A request is taken in the cycle in which the last byte
// of the current burst enters the result register; its burst is then registered.
// Reset clears the frame state and empties both the burst and result registers.
// A stalled rsp_ready holds the result byte, a held burst and requests behind it.
module serial_frame_builder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_op,
   input  logic [7:0] req_dst_node,
   input  logic [7:0] req_src_node,
   input  logic [7:0] req_command,
   input  logic [7:0] req_payload_length,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_frame_last
);

   logic               accept;
   logic               burst_valid;
   logic               burst_free;
   sfb_pkg::burst_type burst;

   assign req_ready = burst_free;
   assign accept    = req_valid && burst_free;

   sfb_framer u_framer (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .op             (req_op),
      .dst_node       (req_dst_node),
      .src_node       (req_src_node),
      .command        (req_command),
      .payload_length (req_payload_length),
      .data_byte      (req_data_byte),
      .burst_valid    (burst_valid),
      .burst          (burst)
   );

   sfb_serializer u_serializer (
      .clock          (clock),
      .reset          (reset),
      .burst_valid    (burst_valid),
      .burst          (burst),
      .burst_free     (burst_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

// ----- design/sfb_checker.sv -----
// ----------------------------------------------------------------------------
// Serial frame builder checker
// Port-level assertions on the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module sfb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_op,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_frame_last
);

   // A pending result transaction must hold until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_frame_last))
      else $error("result transaction dropped or changed while stalled");

   a_last_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_last |-> rsp_out_byte == sfb_pkg::TAIL1_BYTE)
      else $error("end of frame flagged on a byte other than the end byte");

   a_start_emits: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_op |-> ##2 rsp_valid)
      else $error("start transaction produced no result in time");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid directly after reset");

endmodule

bind serial_frame_builder_core sfb_checker u_sfb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_op         (req_op),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_frame_last (rsp_frame_last)
);

// ----- bench/serial_frame_builder_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame builder core testbench
// Sends start and data transactions with random gaps and random result
// stalls, including one long stall that backs the block up. A frame model
// in the bench, or a fixed row, predicts every byte, and each byte taken from
// rsp_ is checked against it in order. A table of directed rows comes first.
// ----------------------------------------------------------------------------
module serial_frame_builder_core_test;

   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;
   localparam logic [3:0] FROM_MODEL = 4'hF;
   localparam int ITEM_TARGET  = 350;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int IDLE_LIMIT   = 2000;

   typedef struct packed {
      logic       op;
      logic [7:0] dst;
      logic [7:0] src;
      logic [7:0] cmd;
      logic [7:0] len;
      logic [7:0] data;
   } frame_item_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } frame_byte_type;

   typedef struct packed {
      frame_item_type item;
      logic [3:0]     fixed_count;
      logic [71:0]    fixed;
   } directed_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_op;
   logic [7:0] req_dst_node;
   logic [7:0] req_src_node;
   logic [7:0] req_command;
   logic [7:0] req_payload_length;
   logic [7:0] req_data_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_frame_last;

   frame_byte_type expected_bytes [$];
   frame_byte_type model_bytes [$];
   logic           frame_open_q;
   logic [7:0]     bytes_remaining;
   logic [7:0]     checksum_acc;
   int             mismatch_count;
   bit             steady;
   bit             hold_request;

   // A fixed row with four or nine bytes ends in a trailer, so its final byte
   // carries the end-of-frame flag.
   directed_row_type directed_rows [0:17] = '{
      '{'{OP_DATA,  8'h00, 8'h00, 8'h00, 8'h00, 8'h5A}, 4'd0, 72'h0},
      '{'{OP_START, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00}, 4'd9, 72'hAA55FFFFFF00_FDCC33},
      '{'{OP_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF}, 4'd9, 72'hAA5500000000_00CC33},
      '{'{OP_DATA,  8'h00, 8'h00, 8'h00, 8'h00, 8'hFF}, 4'd0, 72'h0},
      '{'{OP_START, 8'h01, 8'h02, 8'h03, 8'h01, 8'h00}, 4'd6, 72'hAA5501020301_000000},
      '{'{OP_DATA,  8'h00, 8'h00, 8'h00, 8'h00, 8'hFF}, 4'd4, 72'hFF06CC33_0000000000},
      '{'{OP_START, 8'h12, 8'h34, 8'h56, 8'h03, 8'h00}, FROM_MODEL, 72'h0},
      '{'{OP_DATA,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, FROM_MODEL, 72'h0},
      '{'{OP_START, 8'hA5, 8'h5A, 8'hC3, 8'h02, 8'h00}, FROM_MODEL, 72'h0},
      '{'{OP_DATA,  8'h00, 8'h00, 8'h00, 8'h00, 8'h80}, FROM_MODEL, 72'h0},
      '{'{OP_DATA,  8'h00, 8'h00, 8'h00, 8'h00, 8'h7F}, FROM_MODEL, 72'h0},
      '{'{OP_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00}, 4'd6, 72'hAA55FFFFFFFF_000000},
      '{'{OP_DATA,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, FROM_MODEL, 72'h0},
      '{'{OP_DATA,  8'h00, 8'h00, 8'h00, 8'h00, 8'hFF}, FROM_MODEL, 72'h0},
      '{'{OP_START, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00}, FROM_MODEL, 72'h0},
      '{'{OP_DATA,  8'h00, 8'h00, 8'h00, 8'h00, 8'h55}, FROM_MODEL, 72'h0},
      '{'{OP_DATA,  8'h00, 8'h00, 8'h00, 8'h00, 8'hAA}, 4'd0, 72'h0},
      '{'{OP_START, 8'h80, 8'h01, 8'h7E, 8'h02, 8'h00}, FROM_MODEL, 72'h0}
   };

   serial_frame_builder_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_dst_node       (req_dst_node),
      .req_src_node       (req_src_node),
      .req_command        (req_command),
      .req_payload_length (req_payload_length),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_frame_last     (rsp_frame_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   task automatic emit_byte(input logic [7:0] value, input logic last);
      frame_byte_type fb;
      fb.value = value;
      fb.last  = last;
      model_bytes.push_back(fb);
   endtask

   task automatic advance_frame_model(input frame_item_type it);
      if (it.op == OP_START) begin
         emit_byte(sfb_pkg::HEAD0_BYTE, 1'b0);
         emit_byte(sfb_pkg::HEAD1_BYTE, 1'b0);
         emit_byte(it.dst, 1'b0);
         emit_byte(it.src, 1'b0);
         emit_byte(it.cmd, 1'b0);
         emit_byte(it.len, 1'b0);
         checksum_acc    = it.dst + it.src + it.cmd + it.len;
         bytes_remaining = it.len;
         frame_open_q    = 1'b1;
      end else if (frame_open_q) begin
         emit_byte(it.data, 1'b0);
         checksum_acc    = checksum_acc + it.data;
         bytes_remaining = bytes_remaining - 8'd1;
      end
      if (frame_open_q && bytes_remaining == 8'd0) begin
         emit_byte(checksum_acc, 1'b0);
         emit_byte(sfb_pkg::TAIL0_BYTE, 1'b0);
         emit_byte(sfb_pkg::TAIL1_BYTE, 1'b1);
         frame_open_q = 1'b0;
      end
   endtask

   task automatic send_item(input frame_item_type it, input logic [3:0] fixed_count,
                            input logic [71:0] fixed, output bit was_ignored);
      int gap;
      int k;
      frame_byte_type fb;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op             = it.op;
      req_dst_node       = it.dst;
      req_src_node       = it.src;
      req_command        = it.cmd;
      req_payload_length = it.len;
      req_data_byte      = it.data;
      req_valid          = 1'b1;
      do @(posedge clock); while (!req_ready);
      was_ignored = (it.op == OP_DATA) && !frame_open_q;
      model_bytes.delete();
      advance_frame_model(it);
      if (fixed_count == FROM_MODEL) begin
         foreach (model_bytes[i]) expected_bytes.push_back(model_bytes[i]);
      end else begin
         for (k = 0; k < fixed_count; k++) begin
            fb.value = fixed[71 - 8 * k -: 8];
            fb.last  = (fixed_count == 4'd4 || fixed_count == 4'd9) && k == fixed_count - 1;
            expected_bytes.push_back(fb);
         end
      end
      @(negedge clock);
   endtask

   function automatic frame_item_type random_item(input logic op);
      frame_item_type it;
      it.op   = op;
      it.dst  = 8'($urandom_range(0, 255));
      it.src  = 8'($urandom_range(0, 255));
      it.cmd  = 8'($urandom_range(0, 255));
      it.len  = 8'($urandom_range(0, 255));
      it.data = 8'($urandom_range(0, 255));
      return it;
   endfunction

   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_ready = 1'b1;
            repeat (steady ? $urandom_range(8, 40) : $urandom_range(1, 16)) @(negedge clock);
            n = idle_gap();
            if (n > 0) begin
               rsp_ready = 1'b0;
               repeat (n) @(negedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      frame_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected transaction, byte %02h last %0b",
                     $time, rsp_out_byte, rsp_frame_last);
            mismatch_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.value) begin
               $display("%0t: out_byte expected %02h, got %02h",
                        $time, want.value, rsp_out_byte);
               mismatch_count++;
            end
            if (rsp_frame_last !== want.last) begin
               $display("%0t: frame_last expected %0b, got %0b",
                        $time, want.last, rsp_frame_last);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      frame_item_type it;
      bit             ignored;
      int             counted;
      int             n_data;
      int             r;
      bit             hold_issued;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_op             = OP_START;
      req_dst_node       = 8'h00;
      req_src_node       = 8'h00;
      req_command        = 8'h00;
      req_payload_length = 8'h00;
      req_data_byte      = 8'h00;
      frame_open_q       = 1'b0;
      bytes_remaining    = 8'h00;
      checksum_acc       = 8'h00;
      mismatch_count     = 0;
      steady             = 1'b0;
      hold_request       = 1'b0;
      hold_issued        = 1'b0;
      counted            = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].item, directed_rows[i].fixed_count,
                   directed_rows[i].fixed, ignored);
      end

      while (counted < ITEM_TARGET) begin
         steady = ($urandom_range(0, 4) == 0);
         if (!hold_issued && counted > 120) begin
            hold_request = 1'b1;
            hold_issued  = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 10) begin
            repeat ($urandom_range(1, 3)) begin
               it = random_item(1'($urandom_range(0, 1)));
               send_item(it, FROM_MODEL, 72'h0, ignored);
               if (!ignored) counted++;
            end
         end else begin
            it = random_item(OP_START);
            r  = $urandom_range(0, 99);
            if (r < 15) begin
               it.len = 8'd0;
            end else if (r < 80) begin
               it.len = 8'($urandom_range(1, 6));
            end else if (r < 95) begin
               it.len = 8'($urandom_range(7, 30));
            end else begin
               it.len = 8'($urandom_range(31, 80));
            end
            n_data = int'(it.len);
            // Now and then a frame is cut short and abandoned by the next start.
            if ($urandom_range(0, 9) == 0) begin
               n_data = $urandom_range(0, it.len);
            end
            send_item(it, FROM_MODEL, 72'h0, ignored);
            counted++;
            repeat (n_data) begin
               send_item(random_item(OP_DATA), FROM_MODEL, 72'h0, ignored);
               counted++;
            end
         end
      end

      req_valid = 1'b0;
      steady    = 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
